// ===== src/interval_merge_and_flank_unit_defines.svh =====
// ============================================================================
// Interval merge and flank unit assertion macros
// Shared concurrent assertion forms for the checker of the merge unit.
// ============================================================================
`ifndef INTERVAL_MERGE_AND_FLANK_UNIT_DEFINES_SVH
`define INTERVAL_MERGE_AND_FLANK_UNIT_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define IMFU_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A signal holds its value while a transaction is stalled.
`define IMFU_HOLD(lbl, cond, sig, msg) \
    `IMFU_CHECK(lbl, (cond) |=> $stable(sig), msg)

`endif

// ===== src/imfu_pkg.sv =====
// ============================================================================
// Interval merge and flank unit package
// Field widths, codes and the result record shared by the merge unit files.
// ============================================================================
`default_nettype none

package imfu_pkg;

    // Field widths of the channels and registers.
    localparam int FIELD_W   = 40;
    localparam int FLANK_W   = 31;
    localparam int KIND_W    = 2;
    localparam int ERR_W     = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_SEL_LSB = 3;

    // Results one input transaction can produce, and counters for them.
    localparam int MAX_RESULTS = 4;
    localparam int RIDX_W      = 2;
    localparam int RCNT_W      = 3;

    // Commands.
    localparam logic CMD_INTERVAL = 1'b0;
    localparam logic CMD_FLUSH    = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_TARGET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLANK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    // Error codes, in order of precedence.
    localparam logic [ERR_W-1:0] ERR_NONE           = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_ONE_ORIGIN = 3'd1;
    localparam logic [ERR_W-1:0] ERR_END_NOT_AFTER  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BEYOND_LENGTH  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_UNSORTED       = 3'd4;

    // Register indexes, taken from paddr above the 8-byte word offset.
    localparam logic [1:0] REG_FLANK_BASES  = 2'd0;
    localparam logic [1:0] REG_CHROM_LENGTH = 2'd1;
    localparam logic [1:0] REG_ONE_ORIGIN   = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] region_start;
        logic [FIELD_W-1:0] region_end;
        logic [FIELD_W-1:0] region_length;
        logic [ERR_W-1:0]   error_code;
        logic               last_of_run;
    } result_t;

    // All results of one input transaction, packed from slot zero.
    typedef struct packed {
        logic [RCNT_W-1:0]                 cnt;
        result_t [MAX_RESULTS-1:0]         res;
    } run_t;

    function automatic result_t mk_region(input logic [KIND_W-1:0] kind,
                                          input logic [FIELD_W-1:0] s,
                                          input logic [FIELD_W-1:0] e);
        result_t r;
        r.kind          = kind;
        r.region_start  = s;
        r.region_end    = e;
        r.region_length = e - s;
        r.error_code    = ERR_NONE;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    function automatic result_t mk_error(input logic [ERR_W-1:0] code);
        result_t r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/imfu_if.sv =====
// ============================================================================
// Interval merge and flank unit channel interfaces
// Valid/ready channels for interval items and for emitted regions.
// ============================================================================
`default_nettype none

interface imfu_in_if;
    import imfu_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [FIELD_W-1:0] begin_pos;
    logic [FIELD_W-1:0] end_pos;

    modport source (output valid, cmd, begin_pos, end_pos, input ready);
    modport sink   (input valid, cmd, begin_pos, end_pos, output ready);
endinterface

interface imfu_out_if;
    import imfu_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] region_start;
    logic [FIELD_W-1:0] region_end;
    logic [FIELD_W-1:0] region_length;
    logic [ERR_W-1:0]   error_code;
    logic               last_of_run;

    modport source (output valid, kind, region_start, region_end, region_length,
                    error_code, last_of_run, input ready);
    modport sink   (input valid, kind, region_start, region_end, region_length,
                    error_code, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/interval_merge_and_flank_unit.sv =====
// ============================================================================
// Interval merge and flank unit
// Validates sorted intervals of one chromosome, merges them into targets and
// emits each target in start order together with its clipped flank pieces.
// ============================================================================
// The unit accepts one input transaction per clock cycle while the result
// queue can take its results. Each one is registered, processed in a single
// pass against the merge state and handed to a result queue, which drains
// one result per cycle through the output register while the receiver is
// ready; a transaction with n results (at most four, on a flush) holds the
// queue until all n drain. Transactions that merge into the open target
// produce no result. Configuration must be written through the APB port
// only while the unit is idle (not enforced); no clearing pass follows reset.
`default_nettype none

module interval_merge_and_flank_unit #(
    parameter int COORD_BITS = 40
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    imfu_in_if.sink                               item,
    imfu_out_if.source                            result,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [imfu_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [imfu_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [imfu_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready
);
    import imfu_pkg::*;

    localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

    logic [FLANK_W-1:0] flank_bases;
    logic [CW-1:0]      chrom_length;
    logic               one_origin;
    run_t               run;
    logic               run_valid;
    logic               run_ready;

    // Configuration registers.
    imfu_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .flank_bases  (flank_bases),
        .chrom_length (chrom_length),
        .one_origin   (one_origin)
    );

    // Validation, merging and result formation.
    imfu_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .flank_bases  (flank_bases),
        .chrom_length (chrom_length),
        .one_origin   (one_origin),
        .run          (run),
        .run_valid    (run_valid),
        .run_ready    (run_ready)
    );

    // Result drain.
    imfu_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .run       (run),
        .run_valid (run_valid),
        .run_ready (run_ready),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== src/imfu_cfg_regs.sv =====
// ============================================================================
// Interval merge and flank unit configuration registers
// APB-style register file holding flank size, chromosome length and mode.
// ============================================================================
`default_nettype none

module imfu_cfg_regs #(
    parameter int COORD_BITS = 40
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [imfu_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [imfu_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [imfu_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output logic      [imfu_pkg::FLANK_W-1:0]     flank_bases,
    output logic [((COORD_BITS < imfu_pkg::FIELD_W) ? COORD_BITS
                   : imfu_pkg::FIELD_W)-1:0]      chrom_length,
    output logic                                  one_origin
);
    import imfu_pkg::*;

    localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

    logic [FLANK_W-1:0] flank_reg;
    logic [CW-1:0]      length_reg;
    logic               one_origin_reg;
    logic [1:0]         reg_sel;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[REG_SEL_LSB +: 2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes complete in the access phase.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            flank_reg      <= '0;
            length_reg     <= '0;
            one_origin_reg <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_FLANK_BASES:  flank_reg      <= pwdata[FLANK_W-1:0];
                REG_CHROM_LENGTH: length_reg     <= pwdata[CW-1:0];
                REG_ONE_ORIGIN:   one_origin_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    // Read data decode.
    always_comb begin
        unique case (reg_sel)
            REG_FLANK_BASES:  prdata = CFG_DATA_W'(flank_reg);
            REG_CHROM_LENGTH: prdata = CFG_DATA_W'(length_reg);
            REG_ONE_ORIGIN:   prdata = CFG_DATA_W'(one_origin_reg);
            default:          prdata = '0;
        endcase
    end

    assign flank_bases  = flank_reg;
    assign chrom_length = length_reg;
    assign one_origin   = one_origin_reg;

endmodule

`default_nettype wire

// ===== src/imfu_core.sv =====
// ============================================================================
// Interval merge and flank unit core
// Input register, merge state and the single-pass logic that forms the
// results of one interval or flush transaction.
// ============================================================================
`default_nettype none

module imfu_core #(
    parameter int COORD_BITS = 40
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    imfu_in_if.sink                           item,
    input  wire logic [imfu_pkg::FLANK_W-1:0] flank_bases,
    input  wire logic [((COORD_BITS < imfu_pkg::FIELD_W) ? COORD_BITS
                        : imfu_pkg::FIELD_W)-1:0] chrom_length,
    input  wire logic                         one_origin,
    output imfu_pkg::run_t                    run,
    output logic                              run_valid,
    input  wire logic                         run_ready
);
    import imfu_pkg::*;

    localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int SW = ((CW > FLANK_W) ? CW : FLANK_W) + 1;

    // Result slots before compaction, in emission order.
    localparam int SLOT_GAP_A = 0;
    localparam int SLOT_GAP_B = 1;
    localparam int SLOT_TGT   = 2;
    localparam int SLOT_RIGHT = 3;

    // End of the right flank of a target ending at pe, clipped to len.
    function automatic logic [CW-1:0] right_limit(input logic [CW-1:0] pe,
                                                  input logic [FLANK_W-1:0] fl,
                                                  input logic [CW-1:0] len);
        logic [SW-1:0] sum;
        sum = SW'(pe) + SW'(fl);
        return (sum >= SW'(len)) ? len : sum[CW-1:0];
    endfunction

    logic          a_valid_reg;
    logic          a_cmd_reg;
    logic [CW-1:0] a_begin_reg;
    logic [CW-1:0] a_end_reg;
    logic          advance;

    logic [CW-1:0] open_start_reg, open_start_next;
    logic [CW-1:0] open_end_reg, open_end_next;
    logic          open_valid_reg, open_valid_next;
    logic [CW-1:0] prior_end_reg, prior_end_next;
    logic          prior_valid_reg, prior_valid_next;

    logic [ERR_W-1:0] err;
    logic [CW-1:0]    bc;
    logic [SW-1:0]    left_diff;
    logic [CW-1:0]    left_raw;
    logic [CW-1:0]    left_clip;
    logic [CW-1:0]    lim_prior;
    logic [CW-1:0]    lim_open;
    logic [CW-1:0]    right_clip;
    logic             r_nonempty;
    logic             l_nonempty;
    logic             join_gap;
    logic             close;

    result_t              cand [MAX_RESULTS];
    logic [MAX_RESULTS-1:0] cand_v;
    logic [RCNT_W-1:0]    cnt;

    assign advance    = a_valid_reg && run_ready;
    assign item.ready = !a_valid_reg || advance;
    assign run_valid  = a_valid_reg;

    // Input register: one transaction held while the result side is busy.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end else if (item.valid && item.ready) begin
            a_valid_reg <= 1'b1;
        end else if (advance) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (item.valid && item.ready) begin
            a_cmd_reg   <= item.cmd;
            a_begin_reg <= item.begin_pos[CW-1:0];
            a_end_reg   <= item.end_pos[CW-1:0];
        end
    end

    // Validation of the held interval.
    always_comb begin
        err = ERR_NONE;
        bc  = a_begin_reg;
        if (one_origin) begin
            if (a_begin_reg == '0 || a_end_reg < a_begin_reg) begin
                err = ERR_BAD_ONE_ORIGIN;
            end else begin
                bc = a_begin_reg - 1'b1;
            end
        end else if (a_end_reg <= a_begin_reg) begin
            err = ERR_END_NOT_AFTER;
        end
        if (err == ERR_NONE && a_end_reg > chrom_length) begin
            err = ERR_BEYOND_LENGTH;
        end
        if (err == ERR_NONE && open_valid_reg && bc < open_start_reg) begin
            err = ERR_UNSORTED;
        end
    end

    // Flank in the gap before the open target; depends on state only.
    always_comb begin
        left_diff  = SW'(open_start_reg) - SW'(flank_bases);
        left_raw   = left_diff[SW-1] ? '0 : left_diff[CW-1:0];
        lim_prior  = right_limit(prior_end_reg, flank_bases, chrom_length);
        lim_open   = right_limit(open_end_reg, flank_bases, chrom_length);
        right_clip = (lim_prior > open_start_reg) ? open_start_reg : lim_prior;
        left_clip  = (prior_valid_reg && left_raw < prior_end_reg) ? prior_end_reg
                                                                    : left_raw;
        r_nonempty = right_clip > prior_end_reg;
        l_nonempty = left_clip < open_start_reg;
        join_gap   = r_nonempty && l_nonempty && right_clip >= left_clip;
    end

    // Result slots and next state for the held transaction.
    always_comb begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            cand[i] = '0;
        end
        cand_v           = '0;
        close            = 1'b0;
        open_start_next  = open_start_reg;
        open_end_next    = open_end_reg;
        open_valid_next  = open_valid_reg;
        prior_end_next   = prior_end_reg;
        prior_valid_next = prior_valid_reg;

        // Gap pieces: one joined piece, or right part of prior then left part.
        if (!prior_valid_reg) begin
            cand[SLOT_GAP_B] = mk_region(KIND_FLANK, FIELD_W'(left_raw),
                                         FIELD_W'(open_start_reg));
        end else if (join_gap) begin
            cand[SLOT_GAP_A] = mk_region(KIND_FLANK, FIELD_W'(prior_end_reg),
                                         FIELD_W'(open_start_reg));
        end else begin
            cand[SLOT_GAP_A] = mk_region(KIND_FLANK, FIELD_W'(prior_end_reg),
                                         FIELD_W'(right_clip));
            cand[SLOT_GAP_B] = mk_region(KIND_FLANK, FIELD_W'(left_clip),
                                         FIELD_W'(open_start_reg));
        end
        cand[SLOT_TGT]   = mk_region(KIND_TARGET, FIELD_W'(open_start_reg),
                                     FIELD_W'(open_end_reg));
        cand[SLOT_RIGHT] = mk_region(KIND_FLANK, FIELD_W'(open_end_reg),
                                     FIELD_W'(lim_open));

        if (a_cmd_reg == CMD_FLUSH) begin
            close                = open_valid_reg;
            cand_v[SLOT_RIGHT]   = open_valid_reg && (lim_open > open_end_reg);
            open_start_next      = '0;
            open_end_next        = '0;
            open_valid_next      = 1'b0;
            prior_end_next       = '0;
            prior_valid_next     = 1'b0;
        end else if (err != ERR_NONE) begin
            cand[SLOT_GAP_A]     = mk_error(err);
            cand_v[SLOT_GAP_A]   = 1'b1;
        end else if (open_valid_reg && bc <= open_end_reg) begin
            if (a_end_reg > open_end_reg) begin
                open_end_next = a_end_reg;
            end
        end else begin
            close           = open_valid_reg;
            open_start_next = bc;
            open_end_next   = a_end_reg;
            open_valid_next = 1'b1;
            if (open_valid_reg) begin
                prior_end_next   = open_end_reg;
                prior_valid_next = 1'b1;
            end
        end

        if (close) begin
            if (!prior_valid_reg) begin
                cand_v[SLOT_GAP_B] = left_raw < open_start_reg;
            end else if (join_gap) begin
                cand_v[SLOT_GAP_A] = 1'b1;
            end else begin
                cand_v[SLOT_GAP_A] = r_nonempty;
                cand_v[SLOT_GAP_B] = l_nonempty;
            end
            cand_v[SLOT_TGT] = 1'b1;
        end
    end

    // Pack the present slots from zero and mark the last one.
    always_comb begin
        run = '0;
        cnt = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (cand_v[i]) begin
                run.res[cnt[RIDX_W-1:0]] = cand[i];
                cnt = cnt + 1'b1;
            end
        end
        if (cnt != '0) begin
            run.res[RIDX_W'(cnt - 1'b1)].last_of_run = 1'b1;
        end
        run.cnt = cnt;
    end

    // Merge state advances when the transaction hands its results over.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            open_start_reg  <= '0;
            open_end_reg    <= '0;
            open_valid_reg  <= 1'b0;
            prior_end_reg   <= '0;
            prior_valid_reg <= 1'b0;
        end else if (advance) begin
            open_start_reg  <= open_start_next;
            open_end_reg    <= open_end_next;
            open_valid_reg  <= open_valid_next;
            prior_end_reg   <= prior_end_next;
            prior_valid_reg <= prior_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/imfu_result_queue.sv =====
// ============================================================================
// Interval merge and flank unit result queue
// Holds the results of one transaction and drains them one a cycle through
// the output register while the receiver is ready.
// ============================================================================
`default_nettype none

module imfu_result_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire imfu_pkg::run_t run,
    input  wire logic           run_valid,
    output logic                run_ready,
    imfu_out_if.source          result
);
    import imfu_pkg::*;

    result_t [MAX_RESULTS-1:0] buf_reg;
    logic [RCNT_W-1:0]         rem_reg;
    logic [RIDX_W-1:0]         idx_reg;
    logic                      out_valid_reg;
    result_t                   out_reg;
    logic                      pop;
    logic                      load;

    assign pop       = (rem_reg != '0) && (!out_valid_reg || result.ready);
    assign run_ready = (rem_reg == '0) || (rem_reg == RCNT_W'(1) && pop);
    assign load      = run_valid && run_ready && (run.cnt != '0);

    // Queue bookkeeping: a new run replaces the drained one.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rem_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            rem_reg <= run.cnt;
            idx_reg <= '0;
        end else if (pop) begin
            rem_reg <= rem_reg - 1'b1;
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            buf_reg <= run.res;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (result.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (pop) begin
            out_reg <= buf_reg[idx_reg];
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.kind          = out_reg.kind;
    assign result.region_start  = out_reg.region_start;
    assign result.region_end    = out_reg.region_end;
    assign result.region_length = out_reg.region_length;
    assign result.error_code    = out_reg.error_code;
    assign result.last_of_run   = out_reg.last_of_run;

endmodule

`default_nettype wire

// ===== src/imfu_checker.sv =====
// ============================================================================
// Interval merge and flank unit checker
// Port-level assertions on the result channel, bound to the top level.
// ============================================================================
`default_nettype none

`include "interval_merge_and_flank_unit_defines.svh"

module imfu_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              res_valid,
    input wire logic                              res_ready,
    input wire logic [imfu_pkg::KIND_W-1:0]       res_kind,
    input wire logic [imfu_pkg::FIELD_W-1:0]      res_start,
    input wire logic [imfu_pkg::FIELD_W-1:0]      res_end,
    input wire logic [imfu_pkg::FIELD_W-1:0]      res_length,
    input wire logic [imfu_pkg::ERR_W-1:0]        res_error,
    input wire logic                              res_last
);
    import imfu_pkg::*;

    // A stalled result transaction stays offered.
    `IMFU_CHECK(a_result_valid_held, res_valid && !res_ready |=> res_valid, "result valid dropped while stalled")

    // A stalled result keeps its payload.
    `IMFU_HOLD(a_result_payload_held, res_valid && !res_ready, {res_kind, res_start, res_end, res_length, res_error, res_last}, "result payload changed while stalled")

    // Emitted regions are never empty and carry a consistent length.
    `IMFU_CHECK(a_region_shape, res_valid && res_kind != KIND_ERROR |-> res_end > res_start && res_length == res_end - res_start && res_error == ERR_NONE, "malformed region result")

    // Error reports carry a code, no coordinates, and end their run.
    `IMFU_CHECK(a_error_shape, res_valid && res_kind == KIND_ERROR |-> res_error != ERR_NONE && res_start == '0 && res_end == '0 && res_length == '0 && res_last, "malformed error result")

endmodule

bind interval_merge_and_flank_unit imfu_checker u_imfu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_kind   (result.kind),
    .res_start  (result.region_start),
    .res_end    (result.region_end),
    .res_length (result.region_length),
    .res_error  (result.error_code),
    .res_last   (result.last_of_run)
);

`default_nettype wire

// ===== bench/imfu_checker.sv =====
// ============================================================================
// Interval merge and flank unit checker
// Watches the item, result and register channels of the merge unit, keeps
// its own model of the merge state, and compares every result transaction
// field by field against the oldest predicted region.
// ============================================================================
`default_nettype none

module imfu_scoreboard (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    imfu_in_if                                   item_mon,
    imfu_out_if                                  result_mon,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [imfu_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [imfu_pkg::CFG_DATA_W-1:0] pwdata,
    output int                                   mismatches,
    output int                                   pending
);
    import imfu_pkg::*;

    // Register copies, as last written over the configuration port.
    logic [FIELD_W-1:0] flank_q;
    logic [FIELD_W-1:0] chrom_len_q;
    logic               one_origin_q;

    // Merge state: the open target and the end of the last closed one.
    logic [FIELD_W-1:0] open_start_q;
    logic [FIELD_W-1:0] open_end_q;
    logic               open_valid_q;
    logic [FIELD_W-1:0] prior_end_q;
    logic               prior_valid_q;

    // Regions still owed by the unit, oldest first, and those of one item.
    result_t region_q[$];
    result_t run_q[$];

    function automatic result_t make_region(input logic [KIND_W-1:0] kind,
                                            input logic [FIELD_W-1:0] s,
                                            input logic [FIELD_W-1:0] e);
        result_t r;
        r               = '0;
        r.kind          = kind;
        r.region_start  = s;
        r.region_end    = e;
        r.region_length = e - s;
        return r;
    endfunction

    // End of the right flank of a target ending at e, clipped to the length.
    function automatic logic [FIELD_W-1:0] right_flank_end(input logic [FIELD_W-1:0] e);
        if (e >= chrom_len_q || flank_q >= chrom_len_q - e)
            return chrom_len_q;
        return e + flank_q;
    endfunction

    // Flank pieces in the gap between the last closed target and start s.
    task automatic add_gap_flank(input logic [FIELD_W-1:0] s);
        logic [FIELD_W-1:0] ls;
        logic [FIELD_W-1:0] re;
        ls = (s > flank_q) ? s - flank_q : '0;
        if (!prior_valid_q) begin
            if (ls < s)
                run_q.push_back(make_region(KIND_FLANK, ls, s));
        end
        else begin
            re = right_flank_end(prior_end_q);
            if (re > s)
                re = s;
            if (ls < prior_end_q)
                ls = prior_end_q;
            // Right and left flank that meet become one piece.
            if (re > prior_end_q && ls < s && re >= ls)
                run_q.push_back(make_region(KIND_FLANK, prior_end_q, s));
            else
            begin
                if (re > prior_end_q)
                    run_q.push_back(make_region(KIND_FLANK, prior_end_q, re));
                if (ls < s)
                    run_q.push_back(make_region(KIND_FLANK, ls, s));
            end
        end
    endtask

    task automatic close_target();
        add_gap_flank(open_start_q);
        run_q.push_back(make_region(KIND_TARGET, open_start_q, open_end_q));
        prior_end_q   = open_end_q;
        prior_valid_q = 1'b1;
        open_valid_q  = 1'b0;
    endtask

    // Work out the regions that one accepted item transaction causes.
    task automatic predict_item(input logic cmd, input logic [FIELD_W-1:0] b_in,
                                input logic [FIELD_W-1:0] e_in);
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] e;
        logic [FIELD_W-1:0] re;
        logic [ERR_W-1:0]   code;
        result_t            r;
        run_q.delete();
        if (cmd == CMD_FLUSH) begin
            if (open_valid_q) begin
                close_target();
                re = right_flank_end(prior_end_q);
                if (re > prior_end_q)
                    run_q.push_back(make_region(KIND_FLANK, prior_end_q, re));
            end
            open_start_q  = '0;
            open_end_q    = '0;
            open_valid_q  = 1'b0;
            prior_end_q   = '0;
            prior_valid_q = 1'b0;
        end
        else begin
            b    = b_in;
            e    = e_in;
            code = ERR_NONE;
            // Checks run in order of precedence; the first failure wins.
            if (one_origin_q) begin
                if (b == '0 || e < b)
                    code = ERR_BAD_ONE_ORIGIN;
                else
                    b = b - 1'b1;
            end
            else if (e <= b) begin
                code = ERR_END_NOT_AFTER;
            end
            if (code == ERR_NONE && e > chrom_len_q)
                code = ERR_BEYOND_LENGTH;
            if (code == ERR_NONE && open_valid_q && b < open_start_q)
                code = ERR_UNSORTED;

            if (code != ERR_NONE) begin
                r            = '0;
                r.kind       = KIND_ERROR;
                r.error_code = code;
                run_q.push_back(r);
            end
            else if (open_valid_q && b <= open_end_q) begin
                // Overlapping or touching: grow the open target silently.
                if (e > open_end_q)
                    open_end_q = e;
            end
            else begin
                if (open_valid_q)
                    close_target();
                open_start_q = b;
                open_end_q   = e;
                open_valid_q = 1'b1;
            end
        end
        // Mark the final region of this transaction.
        if (run_q.size() > 0) begin
            r             = run_q.pop_back();
            r.last_of_run = 1'b1;
            run_q.push_back(r);
        end
        foreach (run_q[i])
            region_q.push_back(run_q[i]);
    endtask

    function automatic string show(input result_t r);
        return $sformatf("kind=%0d start=%0h end=%0h length=%0h code=%0d last=%0b",
                         r.kind, r.region_start, r.region_end, r.region_length,
                         r.error_code, r.last_of_run);
    endfunction

    task automatic log_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Compare one result transaction against the oldest expectation.
    task automatic check_result();
        result_t seen;
        result_t want;
        seen.kind          = result_mon.kind;
        seen.region_start  = result_mon.region_start;
        seen.region_end    = result_mon.region_end;
        seen.region_length = result_mon.region_length;
        seen.error_code    = result_mon.error_code;
        seen.last_of_run   = result_mon.last_of_run;
        if (region_q.size() == 0) begin
            log_failure({"result with none expected: ", show(seen)});
        end
        else begin
            want = region_q.pop_front();
            if (want.kind !== seen.kind || want.region_start !== seen.region_start ||
                want.region_end !== seen.region_end ||
                want.region_length !== seen.region_length ||
                want.error_code !== seen.error_code ||
                want.last_of_run !== seen.last_of_run)
                log_failure({"expected ", show(want), ", got ", show(seen)});
        end
    endtask

    // Register writes, item transactions and result transactions, per edge.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            flank_q       = '0;
            chrom_len_q   = '0;
            one_origin_q  = 1'b0;
            open_start_q  = '0;
            open_end_q    = '0;
            open_valid_q  = 1'b0;
            prior_end_q   = '0;
            prior_valid_q = 1'b0;
            region_q.delete();
            pending       = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[REG_SEL_LSB +: 2])
                    REG_FLANK_BASES:  flank_q      = FIELD_W'(pwdata[FLANK_W-1:0]);
                    REG_CHROM_LENGTH: chrom_len_q  = pwdata[FIELD_W-1:0];
                    REG_ONE_ORIGIN:   one_origin_q = pwdata[0];
                    default:          ;
                endcase
            end
            if (item_mon.valid && item_mon.ready)
                predict_item(item_mon.cmd, item_mon.begin_pos, item_mon.end_pos);
            if (result_mon.valid && result_mon.ready)
                check_result();
            pending = region_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_interval_merge_and_flank_unit.sv =====
// ============================================================================
// Interval merge and flank unit testbench
// Drives sorted interval streams, flushes and malformed items through the
// merge unit under several register settings and idling patterns, and takes
// its verdict from the checker that runs beside the unit.
// ============================================================================
`default_nettype none

module tb_interval_merge_and_flank_unit;
    import imfu_pkg::*;

    localparam logic [FIELD_W-1:0] COORD_MAX     = '1;
    localparam logic [FLANK_W-1:0] FLANK_MAX     = '1;
    localparam int                 SEG_ITEMS     = 42;
    localparam int                 HOLD_CYCLES   = 160;
    localparam int                 SETTLE_CYCLES = 12;
    localparam int                 DRAIN_CYCLES  = 20;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    mismatches;
    int                    pending;

    // Idling rates in percent, and the long receiver hold-off.
    int   src_idle_pct;
    int   sink_idle_pct;
    logic hold_req;
    logic hold_on;

    // Stimulus-side view of the settings and of the interval stream.
    logic [FLANK_W-1:0] gen_flank;
    logic [FIELD_W-1:0] gen_len;
    logic               gen_one_origin;
    logic [FIELD_W-1:0] seg_base;
    logic [FIELD_W-1:0] last_start;
    logic [FIELD_W-1:0] reach_end;

    imfu_in_if  item_ch();
    imfu_out_if result_ch();

    interval_merge_and_flank_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    imfu_scoreboard u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_mon   (item_ch),
        .result_mon (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: random back-pressure, or a solid stall while held off.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= !hold_on && ($urandom_range(99) >= sink_idle_pct);
    end

    // Long hold-off of the receiver, counted here once requested.
    initial
    begin
        hold_on <= 1'b0;
        wait (hold_req === 1'b1);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    function automatic logic [FIELD_W-1:0] rand_coord();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[FIELD_W-1:0];
    endfunction

    // Offer one item transaction and return at the edge that accepts it.
    task automatic send_item(input logic cmd, input logic [FIELD_W-1:0] b,
                             input logic [FIELD_W-1:0] e);
        if ($urandom_range(99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        item_ch.valid     <= 1'b1;
        item_ch.cmd       <= cmd;
        item_ch.begin_pos <= b;
        item_ch.end_pos   <= e;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Flush with random contents in the ignored coordinate fields.
    task automatic send_flush();
        send_item(CMD_FLUSH, rand_coord(), rand_coord());
    endtask

    task automatic reset_cursor();
        last_start = seg_base;
        reach_end  = seg_base;
    endtask

    // Stop offering items and let every owed result drain.
    task automatic quiesce();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write: setup phase, then access phase.
    task automatic apb_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, {REG_SEL_LSB{1'b0}}});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [FLANK_W-1:0] flank,
                             input logic [FIELD_W-1:0] len, input logic ob);
        quiesce();
        apb_write(REG_FLANK_BASES, CFG_DATA_W'(flank));
        apb_write(REG_CHROM_LENGTH, CFG_DATA_W'(len));
        apb_write(REG_ONE_ORIGIN, CFG_DATA_W'(ob));
        gen_flank      = flank;
        gen_len        = len;
        gen_one_origin = ob;
    endtask

    // One random transaction: mostly a sorted stream, with flushes,
    // noise and broken items mixed in.
    task automatic random_item();
        int          pick;
        int          gmax;
        logic [63:0] s64;
        logic [63:0] e64;
        pick = $urandom_range(99);
        gmax = (gen_flank > 1000) ? 3000 : 3 * int'(gen_flank) + 10;
        if (pick < 7) begin
            send_flush();
            reset_cursor();
        end
        else if (pick < 13) begin
            send_item(CMD_INTERVAL, rand_coord(), rand_coord());
        end
        else if (pick < 17) begin
            // Out of order start, or an end that does not follow the start.
            if ($urandom_range(1) == 1)
                send_item(CMD_INTERVAL, last_start - 1'b1, last_start + FIELD_W'(3));
            else
                send_item(CMD_INTERVAL, last_start + FIELD_W'(5), last_start + FIELD_W'(4));
        end
        else begin
            pick = $urandom_range(99);
            if (pick < 30)
                s64 = 64'(last_start) + 64'($urandom_range(20));
            else if (pick < 50)
                s64 = 64'(reach_end);
            else if (pick < 60)
                s64 = 64'(reach_end) + 64'($urandom);
            else
                s64 = 64'(reach_end) + 64'($urandom_range(1, gmax));
            e64 = s64 + 64'($urandom_range(1, 60));
            if (e64 <= 64'(gen_len)) begin
                send_item(CMD_INTERVAL, FIELD_W'(s64 + 64'(gen_one_origin)), FIELD_W'(e64));
                last_start = FIELD_W'(s64);
                if (FIELD_W'(e64) > reach_end)
                    reach_end = FIELD_W'(e64);
            end
            else if (e64 <= 64'(COORD_MAX) && $urandom_range(3) == 0) begin
                send_item(CMD_INTERVAL, FIELD_W'(s64), FIELD_W'(e64));
            end
            else begin
                // The stream ran past the chromosome: close it.
                send_flush();
                reset_cursor();
            end
        end
    endtask

    // Main stimulus and verdict.
    initial
    begin
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        item_ch.valid     <= 1'b0;
        item_ch.cmd       <= CMD_INTERVAL;
        item_ch.begin_pos <= '0;
        item_ch.end_pos   <= '0;
        hold_req          <= 1'b0;
        src_idle_pct       = 22;
        sink_idle_pct      = 53;
        seg_base           = '0;
        reset_cursor();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Merging, touching, three error codes and four-region flushes.
        configure(FLANK_W'(50), FIELD_W'(1000), 1'b0);
        send_flush();
        send_item(CMD_INTERVAL, 40'd0, 40'd10);
        send_item(CMD_INTERVAL, 40'd5, 40'd20);
        send_item(CMD_INTERVAL, 40'd20, 40'd30);
        send_item(CMD_INTERVAL, 40'd100, 40'd110);
        send_item(CMD_INTERVAL, 40'd120, 40'd130);
        send_item(CMD_INTERVAL, 40'd50, 40'd60);
        send_item(CMD_INTERVAL, 40'd130, 40'd130);
        send_item(CMD_INTERVAL, 40'd900, 40'd1001);
        send_item(CMD_INTERVAL, 40'd990, 40'd1000);
        send_flush();
        send_item(CMD_INTERVAL, 40'd200, 40'd210);
        send_item(CMD_INTERVAL, 40'd500, 40'd510);
        send_flush();

        // Shrinking the length under an open target drops its right flank.
        send_item(CMD_INTERVAL, 40'd600, 40'd620);
        send_item(CMD_INTERVAL, 40'd700, 40'd710);
        quiesce();
        apb_write(REG_CHROM_LENGTH, CFG_DATA_W'(650));
        gen_len = FIELD_W'(650);
        send_flush();

        // One-based coordinates at the extremes of the range.
        configure(FLANK_MAX, COORD_MAX, 1'b1);
        send_item(CMD_INTERVAL, 40'd0, 40'd5);
        send_item(CMD_INTERVAL, 40'd5, 40'd4);
        send_item(CMD_INTERVAL, 40'd5, 40'd5);
        send_item(CMD_INTERVAL, COORD_MAX, COORD_MAX);
        send_flush();
        send_item(CMD_INTERVAL, 40'd1, COORD_MAX);
        send_flush();

        // Empty chromosome with no flank.
        configure('0, '0, 1'b0);
        send_item(CMD_INTERVAL, 40'd0, 40'd1);
        send_item(CMD_INTERVAL, 40'd0, 40'd0);
        send_item(CMD_INTERVAL, COORD_MAX, COORD_MAX);
        send_flush();

        // Random streams, two settings for each idling pattern.
        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0:
                begin
                    src_idle_pct  = 22;
                    sink_idle_pct = 53;
                end
                1:
                begin
                    src_idle_pct  = 53;
                    sink_idle_pct = 22;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            case (seg)
                0:
                begin
                    configure(FLANK_W'($urandom_range(40)), FIELD_W'(5000), 1'b0);
                    seg_base = '0;
                end
                1:
                begin
                    configure('0, COORD_MAX, 1'b1);
                    seg_base = COORD_MAX - FIELD_W'(32'h0040_0000)
                               - FIELD_W'($urandom_range(1 << 20));
                end
                2:
                begin
                    configure(FLANK_MAX, COORD_MAX, 1'b0);
                    seg_base = rand_coord() >> 1;
                end
                3:
                begin
                    configure(FLANK_W'($urandom_range(200)),
                              FIELD_W'(3000 + $urandom_range(2000)), 1'b1);
                    seg_base = '0;
                end
                4:
                begin
                    configure(FLANK_W'($urandom_range(60)), FIELD_W'(8000), 1'b0);
                    seg_base = '0;
                    hold_req <= 1'b1;
                end
                default:
                begin
                    configure(FLANK_W'(5), COORD_MAX, 1'b0);
                    seg_base = rand_coord() >> 2;
                end
            endcase
            reset_cursor();
            send_flush();
            repeat (SEG_ITEMS) random_item();
        end

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard limit on the run.
    initial
    begin
        #(12 * 400000);
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== interval_merge_and_flank_unit.f =====
+incdir+src
src/imfu_pkg.sv
src/imfu_if.sv
src/imfu_cfg_regs.sv
src/imfu_core.sv
src/imfu_result_queue.sv
src/interval_merge_and_flank_unit.sv
src/imfu_checker.sv
bench/imfu_checker.sv
bench/tb_interval_merge_and_flank_unit.sv
